// ===== rtl/core/spdif_pkg.sv =====
// shared types, constants and register indexes of the spdif frame encoder
package spdif_pkg;

	// frame layout
	localparam int unsigned FRAMES_PER_BLOCK = 192;
	localparam int unsigned FRAME_IDX_W      = 8;
	localparam int unsigned AUDIO_W          = 24;
	localparam int unsigned SUB_DATA_W       = 28;
	localparam int unsigned CELLS_W          = 64;
	localparam int unsigned CS_REG_W         = 64;
	localparam int unsigned CFG_IDX_W        = 2;

	// stream word widths
	localparam int unsigned IN_TDATA_W  = 56;
	localparam int unsigned OUT_TDATA_W = 128;

	// preamble patterns for a preceding line level of zero
	localparam logic [7:0] PRE_X = 8'b1110_0010;
	localparam logic [7:0] PRE_Y = 8'b1110_0100;
	localparam logic [7:0] PRE_Z = 8'b1110_1000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CS_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CS_HIGH = 2'd2;

	// channel status bank codes (frame index bits 7:6)
	localparam logic [1:0] BANK_LOW  = 2'd0;
	localparam logic [1:0] BANK_MID  = 2'd1;
	localparam logic [1:0] BANK_HIGH = 2'd2;

	// one lane's coded subframe, taken as if the line started low
	typedef struct packed {
		logic [CELLS_W-1:0] cells;
		logic               flip;
	} lane_res_t;

endpackage

// ===== rtl/core/spdif_lane.sv =====
// one subframe lane: assembles the subframe, adds parity and biphase-mark codes it
module spdif_lane (
	input  logic [spdif_pkg::AUDIO_W-1:0] audio,
	input  logic                          validity,
	input  logic                          user,
	input  logic                          cs_bit,
	input  logic [7:0]                    preamble,
	output spdif_pkg::lane_res_t          res
);

	localparam int unsigned N      = spdif_pkg::SUB_DATA_W;
	localparam int unsigned STEPS  = $clog2(N);

	logic [N-1:0] sub_word;
	logic [N-2:0] sub_body;
	logic [N-1:0] zeros;
	logic [N-1:0] pre_xor;
	logic [N-1:0] lvl_before;
	logic [N-1:0] tmp [STEPS+1];

	// subframe bits 4 to 31, parity even over the rest
	assign sub_body = {cs_bit, user, validity, audio};
	assign sub_word = {^sub_body, sub_body};
	assign zeros    = ~sub_word;

	// log-depth prefix xor: each zero bit toggles the level at the end of its cell pair
	always_comb begin
		tmp[0] = zeros;
		for (int s = 0; s < STEPS; s++) begin
			for (int i = 0; i < N; i++) begin
				if (i >= (1 << s)) begin
					tmp[s+1][i] = tmp[s][i] ^ tmp[s][i - (1 << s)];
				end else begin
					tmp[s+1][i] = tmp[s][i];
				end
			end
		end
	end
	assign pre_xor    = tmp[STEPS];
	assign lvl_before = {pre_xor[N-2:0], 1'b0};

	// cells: preamble on top, then two cells per bit, first sent in the msb
	always_comb begin
		res.cells[spdif_pkg::CELLS_W-1 -: 8] = preamble;
		for (int i = 0; i < N; i++) begin
			res.cells[55 - 2*i] = ~lvl_before[i];
			res.cells[54 - 2*i] = sub_word[i] ? lvl_before[i] : ~lvl_before[i];
		end
		res.flip = pre_xor[N-1];
	end

endmodule

// ===== rtl/core/spdif_merge.sv =====
// merging stage: applies the running line level to both lanes and holds the output word
module spdif_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  spdif_pkg::lane_res_t                  lane_l,
	input  spdif_pkg::lane_res_t                  lane_r,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [spdif_pkg::OUT_TDATA_W-1:0]     out_data
);

	localparam int unsigned CW = spdif_pkg::CELLS_W;

	logic          out_valid_q;
	logic          line_level_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] right_q;
	logic          right_start;

	assign in_ready    = !out_valid_q || out_ready;
	assign right_start = line_level_q ^ lane_l.flip;

	// output valid and kept line level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			line_level_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
			if (in_valid) begin
				line_level_q <= right_start ^ lane_r.flip;
			end
		end
	end

	// output word, inverted where the line starts high
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			left_q  <= lane_l.cells ^ {CW{line_level_q}};
			right_q <= lane_r.cells ^ {CW{right_start}};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {right_q, left_q};

endmodule

// ===== rtl/core/spdif_frame_encoder_unit.sv =====
// top level of the spdif frame encoder
//
// Takes one stereo frame per word on the s_axis channel and returns both
// subframes as biphase-mark line cells on the m_axis channel.
// Input word: two 24-bit samples with their validity and user bits.
// Output word: 64 cells of the left subframe, then 64 of the right,
// first sent cell in the top bit of each half.
// Channel status for the 192-frame block comes from three 64-bit registers
// written through the cfg port; the user must write them only while the
// block is idle, as the block does not enforce it. Throughput: one frame
// per cycle unless the receiver stalls; the two subframe lanes code in
// parallel in the first stage and the merging stage applies the kept
// line level. Reset clears the frame counter (next frame is frame 0,
// preamble Z), the line level, the status registers and both valid flags.
// When the receiver stalls the output word holds and s_axis_tready drops
// once the lane stage holds a frame.
module spdif_frame_encoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// left_audio[23:0], left_validity, left_user, right_audio, right_validity,
	// right_user, zero pad
	input  logic [spdif_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// left_cells[63:0], right_cells[127:64]
	output logic [spdif_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic                                  cfg_we,
	input  logic [spdif_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spdif_pkg::CS_REG_W-1:0]        cfg_wdata
);

	localparam int unsigned FW = spdif_pkg::FRAME_IDX_W;
	localparam logic [FW-1:0] LAST_FRAME = FW'(spdif_pkg::FRAMES_PER_BLOCK - 1);

	logic [spdif_pkg::CS_REG_W-1:0] cs_low_q;
	logic [spdif_pkg::CS_REG_W-1:0] cs_mid_q;
	logic [spdif_pkg::CS_REG_W-1:0] cs_high_q;
	logic [FW-1:0]                  frame_idx_q;
	logic [spdif_pkg::CS_REG_W-1:0] cs_word;
	logic                           cs_bit;
	logic [7:0]                     pre_left;
	logic                           accept;
	logic                           merge_ready;
	logic                           valid_s1;
	spdif_pkg::lane_res_t           lane_l;
	spdif_pkg::lane_res_t           lane_r;
	spdif_pkg::lane_res_t           lane_l_s1;
	spdif_pkg::lane_res_t           lane_r_s1;

	// channel status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_low_q  <= '0;
			cs_mid_q  <= '0;
			cs_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spdif_pkg::CFG_CS_LOW:  cs_low_q  <= cfg_wdata;
				spdif_pkg::CFG_CS_MID:  cs_mid_q  <= cfg_wdata;
				spdif_pkg::CFG_CS_HIGH: cs_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// status bit and left preamble for the current frame
	always_comb begin
		unique case (frame_idx_q[7:6])
			spdif_pkg::BANK_LOW:  cs_word = cs_low_q;
			spdif_pkg::BANK_MID:  cs_word = cs_mid_q;
			spdif_pkg::BANK_HIGH: cs_word = cs_high_q;
			default:              cs_word = '0;
		endcase
	end
	assign cs_bit   = cs_word[frame_idx_q[5:0]];
	assign pre_left = (frame_idx_q == '0) ? spdif_pkg::PRE_Z : spdif_pkg::PRE_X;

	assign s_axis_tready = !valid_s1 || merge_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// frame counter within the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_idx_q <= '0;
		end else if (accept) begin
			frame_idx_q <= (frame_idx_q == LAST_FRAME) ? '0 : frame_idx_q + 1'b1;
		end
	end

	// subframe lanes
	spdif_lane u_lane_left (
		.audio    (s_axis_tdata[23:0]),
		.validity (s_axis_tdata[24]),
		.user     (s_axis_tdata[25]),
		.cs_bit   (cs_bit),
		.preamble (pre_left),
		.res      (lane_l)
	);

	spdif_lane u_lane_right (
		.audio    (s_axis_tdata[49:26]),
		.validity (s_axis_tdata[50]),
		.user     (s_axis_tdata[51]),
		.cs_bit   (cs_bit),
		.preamble (spdif_pkg::PRE_Y),
		.res      (lane_r)
	);

	// lane stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lane_l_s1 <= lane_l;
			lane_r_s1 <= lane_r;
		end
	end

	// merging stage and output register
	spdif_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (merge_ready),
		.lane_l    (lane_l_s1),
		.lane_r    (lane_r_s1),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== rtl/core/spdif_checker.sv =====
// port-level checker for the spdif frame encoder, bound to the top level
module spdif_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic [spdif_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready
);

	localparam logic [62:0] PAIR_START = 63'h0AA_AAAA_AAAA_AAAA;

	logic [63:0] left_cells;
	logic [63:0] right_cells;

	assign left_cells  = m_axis_tdata[63:0];
	assign right_cells = m_axis_tdata[127:64];

	// a stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// left preamble is X or Z at either line level, right preamble is Y
	a_preamble: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(left_cells[63:56] == spdif_pkg::PRE_X || left_cells[63:56] == ~spdif_pkg::PRE_X ||
			 left_cells[63:56] == spdif_pkg::PRE_Z || left_cells[63:56] == ~spdif_pkg::PRE_Z) &&
			(right_cells[63:56] == spdif_pkg::PRE_Y || right_cells[63:56] == ~spdif_pkg::PRE_Y))
		else $error("bad preamble");

	// every data bit opens with a level change
	a_biphase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			((((left_cells[62:0] ^ left_cells[63:1]) & PAIR_START) == PAIR_START) &&
			 (((right_cells[62:0] ^ right_cells[63:1]) & PAIR_START) == PAIR_START)))
		else $error("missing transition at start of data bit");

	// the right subframe continues from the last left cell
	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> right_cells[63] != left_cells[0])
		else $error("right subframe does not follow left line level");

endmodule

bind spdif_frame_encoder_unit spdif_checker u_spdif_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
